// ----- rtl/tdhms_pkg.sv -----
`timescale 1ns / 1ps
// tdhms_pkg: shared types, operation codes and reduction constants for the
// time of day h:m:s adjust unit. No dependencies.
package tdhms_pkg;

    localparam int SEC_PER_MIN  = 60;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_DAY  = 86400;
    localparam int HOURS_PER_DAY = 24;

    // operation codes
    localparam logic [2:0] FN_LOAD = 3'd0;
    localparam logic [2:0] FN_ADD  = 3'd1;
    localparam logic [2:0] FN_SUB  = 3'd2;
    localparam logic [2:0] FN_INC  = 3'd3;
    localparam logic [2:0] FN_DEC  = 3'd4;

    // width of the signed total before reduction
    localparam int VAL_W = 34;
    localparam int REM_W = 17;
    localparam int SUM_W = 19;

    // residues of byte weights modulo one day
    localparam logic [16:0] RES_B0  = 17'd1;
    localparam logic [16:0] RES_B1  = 17'((64'd1 << 8) % 64'(SEC_PER_DAY));
    localparam logic [16:0] RES_B2  = 17'((64'd1 << 16) % 64'(SEC_PER_DAY));
    localparam logic [16:0] RES_B3  = 17'((64'd1 << 24) % 64'(SEC_PER_DAY));
    localparam logic [16:0] RES_B32 = 17'((64'd1 << 32) % 64'(SEC_PER_DAY));
    // bit 33 carries weight -2^33
    localparam logic [16:0] RES_N33 =
        17'(64'(SEC_PER_DAY) - ((64'd1 << 33) % 64'(SEC_PER_DAY)));

    // reciprocal constants for division by 60
    localparam logic [17:0] MUL60_R   = 18'd139811;
    localparam int          SHR60_R   = 23;
    localparam logic [10:0] MUL60_Q   = 11'd1093;
    localparam int          SHR60_Q   = 16;

    typedef logic [255:0][16:0] t_tab;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_hms;

    function automatic t_tab mk_tab(input logic [16:0] step);
        t_tab        tab;
        logic [17:0] acc;
        acc = '0;
        for (int k = 0; k < 256; k++) begin
            tab[k] = acc[16:0];
            acc = acc + 18'(step);
            if (acc >= 18'(SEC_PER_DAY)) begin
                acc = acc - 18'(SEC_PER_DAY);
            end
        end
        return tab;
    endfunction

    localparam t_tab TAB0 = mk_tab(RES_B0);
    localparam t_tab TAB1 = mk_tab(RES_B1);
    localparam t_tab TAB2 = mk_tab(RES_B2);
    localparam t_tab TAB3 = mk_tab(RES_B3);

endpackage

// ----- rtl/tdhms_delta.sv -----
`timescale 1ns / 1ps
// tdhms_delta: input register and signed seconds total for each operation.
// Depends on tdhms_pkg.
module tdhms_delta import tdhms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic [2:0]              i_func,
    input  logic signed [31:0]      i_amount,
    input  logic signed [15:0]      i_lh,
    input  logic signed [15:0]      i_lm,
    input  logic signed [15:0]      i_ls,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output logic signed [VAL_W-1:0] o_value,
    output logic                    o_load
);

    logic                    r_a_vld;
    logic [2:0]              r_func;
    logic signed [31:0]      r_amount;
    logic signed [15:0]      r_lh;
    logic signed [15:0]      r_lm;
    logic signed [15:0]      r_ls;
    logic                    r_b_vld;
    logic signed [VAL_W-1:0] r_value;
    logic                    r_load;
    logic signed [VAL_W-1:0] n_value;
    logic                    rdy_a;
    logic                    rdy_b;

    assign rdy_b = !r_b_vld || i_rdy;
    assign rdy_a = !r_a_vld || rdy_b;

    always_comb begin
        case (r_func)
            FN_LOAD: begin
                n_value = VAL_W'(r_lh) * VAL_W'(SEC_PER_HOUR)
                        + VAL_W'(r_lm) * VAL_W'(SEC_PER_MIN)
                        + VAL_W'(r_ls);
            end
            FN_ADD:  n_value = VAL_W'(r_amount);
            FN_SUB:  n_value = -VAL_W'(r_amount);
            FN_INC:  n_value = VAL_W'(1);
            FN_DEC:  n_value = -VAL_W'(1);
            default: n_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_vld <= i_vld;
            end
            if (rdy_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_vld) begin
            r_func   <= i_func;
            r_amount <= i_amount;
            r_lh     <= i_lh;
            r_lm     <= i_lm;
            r_ls     <= i_ls;
        end
        if (rdy_b && r_a_vld) begin
            r_value <= n_value;
            r_load  <= (r_func == FN_LOAD);
        end
    end

    assign o_rdy   = rdy_a;
    assign o_vld   = r_b_vld;
    assign o_value = r_value;
    assign o_load  = r_load;

endmodule

// ----- rtl/tdhms_mod.sv -----
`timescale 1ns / 1ps
// tdhms_mod: floored reduction of the signed total modulo one day, by byte
// residue tables and a final compare-subtract. Depends on tdhms_pkg.
module tdhms_mod import tdhms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    output logic                    o_rdy,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_load,
    output logic                    o_vld,
    input  logic                    i_rdy,
    output logic [REM_W-1:0]        o_rem,
    output logic                    o_load
);

    localparam logic [SUM_W-1:0] DAY1 = SUM_W'(SEC_PER_DAY);
    localparam logic [SUM_W-1:0] DAY2 = SUM_W'(2 * SEC_PER_DAY);
    localparam logic [SUM_W-1:0] DAY3 = SUM_W'(3 * SEC_PER_DAY);
    localparam logic [SUM_W-1:0] DAY4 = SUM_W'(4 * SEC_PER_DAY);
    localparam logic [SUM_W-1:0] DAY5 = SUM_W'(5 * SEC_PER_DAY);

    logic             r_c_vld;
    logic [SUM_W-1:0] r_sum;
    logic             r_c_load;
    logic             r_d_vld;
    logic [REM_W-1:0] r_rem;
    logic             r_d_load;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] n_red;
    logic             rdy_c;
    logic             rdy_d;

    assign rdy_d = !r_d_vld || i_rdy;
    assign rdy_c = !r_c_vld || rdy_d;

    always_comb begin
        n_sum = SUM_W'(TAB0[i_value[7:0]])
              + SUM_W'(TAB1[i_value[15:8]])
              + SUM_W'(TAB2[i_value[23:16]])
              + SUM_W'(TAB3[i_value[31:24]])
              + (i_value[32] ? SUM_W'(RES_B32) : '0)
              + (i_value[33] ? SUM_W'(RES_N33) : '0);
    end

    always_comb begin
        if (r_sum >= DAY5) begin
            n_red = r_sum - DAY5;
        end else if (r_sum >= DAY4) begin
            n_red = r_sum - DAY4;
        end else if (r_sum >= DAY3) begin
            n_red = r_sum - DAY3;
        end else if (r_sum >= DAY2) begin
            n_red = r_sum - DAY2;
        end else if (r_sum >= DAY1) begin
            n_red = r_sum - DAY1;
        end else begin
            n_red = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (rdy_c) begin
                r_c_vld <= i_vld;
            end
            if (rdy_d) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && i_vld) begin
            r_sum    <= n_sum;
            r_c_load <= i_load;
        end
        if (rdy_d && r_c_vld) begin
            r_rem    <= n_red[REM_W-1:0];
            r_d_load <= r_c_load;
        end
    end

    assign o_rdy  = rdy_c;
    assign o_vld  = r_d_vld;
    assign o_rem  = r_rem;
    assign o_load = r_d_load;

endmodule

// ----- rtl/tdhms_split.sv -----
`timescale 1ns / 1ps
// tdhms_split: splits seconds of day into hours, minutes and seconds with
// reciprocal multiplies by 1/60. Depends on tdhms_pkg.
module tdhms_split import tdhms_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    output logic             o_rdy,
    input  logic [REM_W-1:0] i_rem,
    input  logic             i_load,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_hms             o_delta,
    output logic             o_load
);

    logic             r_e_vld;
    logic [REM_W-1:0] r_e_rem;
    logic [10:0]      r_e_q;
    logic             r_e_load;
    logic             r_f_vld;
    logic [10:0]      r_f_q;
    logic [5:0]       r_f_sec;
    logic [4:0]       r_f_hr;
    logic             r_f_load;
    logic             r_g_vld;
    t_hms             r_g_hms;
    logic             r_g_load;
    logic [34:0]      prod_r;
    logic [REM_W-1:0] q60;
    logic [REM_W-1:0] sec_diff;
    logic [21:0]      prod_q;
    logic [10:0]      h60;
    logic [10:0]      min_diff;
    logic             rdy_e;
    logic             rdy_f;
    logic             rdy_g;

    assign rdy_g = !r_g_vld || i_rdy;
    assign rdy_f = !r_f_vld || rdy_g;
    assign rdy_e = !r_e_vld || rdy_f;

    assign prod_r   = 35'(i_rem) * 35'(MUL60_R);
    assign q60      = {r_e_q, 6'b0} - REM_W'({r_e_q, 2'b0});
    assign sec_diff = r_e_rem - q60;
    assign prod_q   = 22'(r_e_q) * 22'(MUL60_Q);
    assign h60      = {r_f_hr, 6'b0} - 11'({r_f_hr, 2'b0});
    assign min_diff = r_f_q - h60;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else begin
            if (rdy_e) begin
                r_e_vld <= i_vld;
            end
            if (rdy_f) begin
                r_f_vld <= r_e_vld;
            end
            if (rdy_g) begin
                r_g_vld <= r_f_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_e && i_vld) begin
            r_e_rem  <= i_rem;
            r_e_q    <= prod_r[SHR60_R+10:SHR60_R];
            r_e_load <= i_load;
        end
        if (rdy_f && r_e_vld) begin
            r_f_q    <= r_e_q;
            r_f_sec  <= sec_diff[5:0];
            r_f_hr   <= prod_q[SHR60_Q+4:SHR60_Q];
            r_f_load <= r_e_load;
        end
        if (rdy_g && r_f_vld) begin
            r_g_hms.hours   <= r_f_hr;
            r_g_hms.minutes <= min_diff[5:0];
            r_g_hms.seconds <= r_f_sec;
            r_g_load        <= r_f_load;
        end
    end

    assign o_rdy   = rdy_e;
    assign o_vld   = r_g_vld;
    assign o_delta = r_g_hms;
    assign o_load  = r_g_load;

endmodule

// ----- rtl/tdhms_acc.sv -----
`timescale 1ns / 1ps
// tdhms_acc: held time of day, mixed-radix add of the reduced offset or a load of
// it, and the result register with new and old time. Depends on tdhms_pkg.
module tdhms_acc import tdhms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_hms i_delta,
    input  logic i_load,
    output logic o_vld,
    input  logic i_rdy,
    output t_hms o_new,
    output t_hms o_old
);

    t_hms       r_time;
    t_hms       r_new;
    t_hms       r_old;
    logic       r_vld;
    t_hms       n_time;
    logic [6:0] s_sum;
    logic [6:0] m_sum;
    logic [5:0] h_sum;
    logic       c_sec;
    logic       c_min;
    logic       rdy;
    logic       take;

    assign rdy  = !r_vld || i_rdy;
    assign take = rdy && i_vld;

    always_comb begin
        s_sum = 7'(r_time.seconds) + 7'(i_delta.seconds);
        c_sec = (s_sum >= 7'(SEC_PER_MIN));
        m_sum = 7'(r_time.minutes) + 7'(i_delta.minutes) + 7'(c_sec);
        c_min = (m_sum >= 7'(SEC_PER_MIN));
        h_sum = 6'(r_time.hours) + 6'(i_delta.hours) + 6'(c_min);
        if (i_load) begin
            n_time = i_delta;
        end else begin
            n_time.seconds = c_sec ? 6'(s_sum - 7'(SEC_PER_MIN)) : s_sum[5:0];
            n_time.minutes = c_min ? 6'(m_sum - 7'(SEC_PER_MIN)) : m_sum[5:0];
            n_time.hours   = (h_sum >= 6'(HOURS_PER_DAY)) ?
                             5'(h_sum - 6'(HOURS_PER_DAY)) : h_sum[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_time <= '0;
        end else begin
            if (rdy) begin
                r_vld <= i_vld;
            end
            if (take) begin
                r_time <= n_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_new <= n_time;
            r_old <= r_time;
        end
    end

    assign o_rdy = rdy;
    assign o_vld = r_vld;
    assign o_new = r_new;
    assign o_old = r_old;

endmodule

// ----- rtl/time_of_day_hms_adjust_unit.sv -----
`timescale 1ns / 1ps
// time_of_day_hms_adjust_unit: top level of the h:m:s time of day adjust unit.
// Depends on tdhms_pkg, tdhms_delta, tdhms_mod, tdhms_split, tdhms_acc.
//
//   channel  direction  handshake          payload
//   input    in         i_valid, o_stall   i_func, i_amount_seconds, i_load_*
//   output   out        o_valid, i_stall   o_hours..o_seconds, o_old_*
//
// one item per cycle sustained while the output is not stalled
// the offset path (7 stages) does not depend on the held time; only the last
// stage, a mixed-radix add into the time register, closes the loop
// synchronous active-low reset clears all valids and the time to 00:00:00
// each stage holds while the next one is full and stalled, so bubbles close up
module time_of_day_hms_adjust_unit import tdhms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_amount_seconds,
    input  logic signed [15:0] i_load_hours,
    input  logic signed [15:0] i_load_minutes,
    input  logic signed [15:0] i_load_seconds,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [4:0]         o_hours,
    output logic [5:0]         o_minutes,
    output logic [5:0]         o_seconds,
    output logic [4:0]         o_old_hours,
    output logic [5:0]         o_old_minutes,
    output logic [5:0]         o_old_seconds
);

    logic                    in_rdy;
    logic                    dl_vld;
    logic                    dl_rdy;
    logic signed [VAL_W-1:0] dl_value;
    logic                    dl_load;
    logic                    md_vld;
    logic                    md_rdy;
    logic [REM_W-1:0]        md_rem;
    logic                    md_load;
    logic                    sp_vld;
    logic                    sp_rdy;
    t_hms                    sp_delta;
    logic                    sp_load;
    t_hms                    new_time;
    t_hms                    old_time;

    tdhms_delta u_delta (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_valid),
        .o_rdy    (in_rdy),
        .i_func   (i_func),
        .i_amount (i_amount_seconds),
        .i_lh     (i_load_hours),
        .i_lm     (i_load_minutes),
        .i_ls     (i_load_seconds),
        .o_vld    (dl_vld),
        .i_rdy    (dl_rdy),
        .o_value  (dl_value),
        .o_load   (dl_load)
    );

    tdhms_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dl_vld),
        .o_rdy   (dl_rdy),
        .i_value (dl_value),
        .i_load  (dl_load),
        .o_vld   (md_vld),
        .i_rdy   (md_rdy),
        .o_rem   (md_rem),
        .o_load  (md_load)
    );

    tdhms_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (md_vld),
        .o_rdy   (md_rdy),
        .i_rem   (md_rem),
        .i_load  (md_load),
        .o_vld   (sp_vld),
        .i_rdy   (sp_rdy),
        .o_delta (sp_delta),
        .o_load  (sp_load)
    );

    tdhms_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sp_vld),
        .o_rdy   (sp_rdy),
        .i_delta (sp_delta),
        .i_load  (sp_load),
        .o_vld   (o_valid),
        .i_rdy   (!i_stall),
        .o_new   (new_time),
        .o_old   (old_time)
    );

    assign o_stall       = !in_rdy;
    assign o_hours       = new_time.hours;
    assign o_minutes     = new_time.minutes;
    assign o_seconds     = new_time.seconds;
    assign o_old_hours   = old_time.hours;
    assign o_old_minutes = old_time.minutes;
    assign o_old_seconds = old_time.seconds;

endmodule

// ----- dv/tdhms_checker.sv -----
`timescale 1ns / 1ps
// tdhms_checker: watches both channels of time_of_day_hms_adjust_unit, predicts
// the new and old h:m:s of every accepted item and compares them in order
// depends on tdhms_pkg for t_hms, the operation codes and the time constants
module tdhms_checker import tdhms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_amount_seconds,
    input  logic signed [15:0] i_load_hours,
    input  logic signed [15:0] i_load_minutes,
    input  logic signed [15:0] i_load_seconds,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [4:0]         i_hours,
    input  logic [5:0]         i_minutes,
    input  logic [5:0]         i_seconds,
    input  logic [4:0]         i_old_hours,
    input  logic [5:0]         i_old_minutes,
    input  logic [5:0]         i_old_seconds,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        t_hms fresh;
        t_hms old;
    } t_hms_pair;

    t_hms      held_time;
    t_hms_pair expected_times[$];
    int        fail_count = 0;
    int        pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic t_hms adjusted_time(
        input t_hms               now,
        input logic [2:0]         op,
        input logic signed [31:0] amount,
        input logic signed [15:0] lh,
        input logic signed [15:0] lm,
        input logic signed [15:0] ls
    );
        longint held_secs;
        longint total;
        longint day_secs;
        t_hms   res;
        held_secs = longint'(now.hours) * SEC_PER_HOUR
                  + longint'(now.minutes) * SEC_PER_MIN + longint'(now.seconds);
        case (op)
            FN_LOAD: total = longint'(lh) * SEC_PER_HOUR + longint'(lm) * SEC_PER_MIN
                           + longint'(ls);
            FN_ADD:  total = held_secs + longint'(amount);
            FN_SUB:  total = held_secs - longint'(amount);
            FN_INC:  total = held_secs + 1;
            FN_DEC:  total = held_secs - 1;
            default: return now;
        endcase
        // floored reduction into one day
        day_secs = total % SEC_PER_DAY;
        if (day_secs < 0) begin
            day_secs = day_secs + SEC_PER_DAY;
        end
        res.hours   = 5'(day_secs / SEC_PER_HOUR);
        res.minutes = 6'((day_secs / SEC_PER_MIN) % SEC_PER_MIN);
        res.seconds = 6'(day_secs % SEC_PER_MIN);
        return res;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_hms_pair pair;
        if (!i_rst_n) begin
            held_time = '0;
            expected_times.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                pair.old   = held_time;
                pair.fresh = adjusted_time(held_time, i_func, i_amount_seconds,
                                           i_load_hours, i_load_minutes, i_load_seconds);
                held_time  = pair.fresh;
                expected_times.push_back(pair);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    $display("%0t ns: unexpected item, expected none, actual %0d:%0d:%0d",
                             $time, i_hours, i_minutes, i_seconds);
                    fail_count++;
                end else begin
                    pair = expected_times.pop_front();
                    check_field("hours", int'(pair.fresh.hours), int'(i_hours));
                    check_field("minutes", int'(pair.fresh.minutes), int'(i_minutes));
                    check_field("seconds", int'(pair.fresh.seconds), int'(i_seconds));
                    check_field("old_hours", int'(pair.old.hours), int'(i_old_hours));
                    check_field("old_minutes", int'(pair.old.minutes),
                                int'(i_old_minutes));
                    check_field("old_seconds", int'(pair.old.seconds),
                                int'(i_old_seconds));
                end
            end
        end
        pending = expected_times.size();
    end

endmodule

// ----- dv/tb_time_of_day_hms_adjust_unit.sv -----
`timescale 1ns / 1ps
// tb_time_of_day_hms_adjust_unit: drives directed and random items into the
// adjust unit with random idling on both sides and gives the verdict
// depends on tdhms_pkg, tdhms_checker and the time_of_day_hms_adjust_unit rtl
module tb_time_of_day_hms_adjust_unit;
    import tdhms_pkg::*;

    localparam int         RESET_CYCLES = 7;
    localparam int         IDLE_PCT     = 13;
    localparam int         RANDOM_ITEMS = 1630;
    localparam int         DRAIN_CYCLES = 40;
    localparam logic [2:0] FN_UNUSED_LO = 3'd5;
    localparam logic [2:0] FN_UNUSED_HI = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_func = FN_LOAD;
    logic signed [31:0] i_amount_seconds = '0;
    logic signed [15:0] i_load_hours = '0;
    logic signed [15:0] i_load_minutes = '0;
    logic signed [15:0] i_load_seconds = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [4:0]         o_hours;
    logic [5:0]         o_minutes;
    logic [5:0]         o_seconds;
    logic [4:0]         o_old_hours;
    logic [5:0]         o_old_minutes;
    logic [5:0]         o_old_seconds;
    int                 fail_count;
    int                 pending;
    bit                 idle_on = 1'b1;

    always #6 i_clk = ~i_clk;

    time_of_day_hms_adjust_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_amount_seconds (i_amount_seconds),
        .i_load_hours     (i_load_hours),
        .i_load_minutes   (i_load_minutes),
        .i_load_seconds   (i_load_seconds),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_hours          (o_hours),
        .o_minutes        (o_minutes),
        .o_seconds        (o_seconds),
        .o_old_hours      (o_old_hours),
        .o_old_minutes    (o_old_minutes),
        .o_old_seconds    (o_old_seconds)
    );

    tdhms_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_func           (i_func),
        .i_amount_seconds (i_amount_seconds),
        .i_load_hours     (i_load_hours),
        .i_load_minutes   (i_load_minutes),
        .i_load_seconds   (i_load_seconds),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_hours          (o_hours),
        .i_minutes        (o_minutes),
        .i_seconds        (o_seconds),
        .i_old_hours      (o_old_hours),
        .i_old_minutes    (o_old_minutes),
        .i_old_seconds    (o_old_seconds),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_item(
        input logic [2:0]  op,
        input logic [31:0] amount,
        input logic [15:0] lh,
        input logic [15:0] lm,
        input logic [15:0] ls
    );
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= op;
        i_amount_seconds <= amount;
        i_load_hours     <= lh;
        i_load_minutes   <= lm;
        i_load_seconds   <= ls;
        do @(posedge i_clk); while (o_stall);
    endtask

    // ignored fields always carry random noise
    task automatic send_op(input logic [2:0] op, input logic [31:0] amount);
        send_item(op, amount, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_load(input logic [15:0] lh, input logic [15:0] lm,
                             input logic [15:0] ls);
        send_item(FN_LOAD, $urandom, lh, lm, ls);
    endtask

    task automatic send_random_item();
        logic [2:0]  op;
        logic [31:0] amount;
        logic [15:0] lh;
        logic [15:0] lm;
        logic [15:0] ls;
        if ($urandom_range(0, 99) < 6) begin
            op = 3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        end else begin
            op = 3'($urandom_range(FN_LOAD, FN_DEC));
        end
        amount = $urandom;
        case ($urandom_range(0, 3))
            0: amount = 32'(int'($urandom_range(0, 400)) - 200);
            1: amount = 32'(int'($urandom_range(0, 2 * SEC_PER_DAY)) - SEC_PER_DAY);
            default: ;
        endcase
        lh = 16'($urandom);
        lm = 16'($urandom);
        ls = 16'($urandom);
        if ($urandom_range(0, 1) == 0) begin
            lh = 16'(int'($urandom_range(0, 60)) - 12);
            lm = 16'(int'($urandom_range(0, 160)) - 40);
            ls = 16'(int'($urandom_range(0, 160)) - 40);
        end
        send_item(op, amount, lh, lm, ls);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, wraps and every operation
        send_op(FN_INC, $urandom);
        send_load(16'sd0, 16'sd0, 16'sd0);
        send_op(FN_DEC, $urandom);
        send_load(16'sd23, 16'sd59, 16'sd59);
        send_op(FN_INC, $urandom);
        send_load(16'sd32767, 16'sd32767, 16'sd32767);
        send_load(-16'sd32768, -16'sd32768, -16'sd32768);
        send_load(-16'sd1, 16'sd0, 16'sd0);
        send_load(16'sd0, 16'sd0, -16'sd1);
        send_load(16'sd24, 16'sd60, 16'sd60);
        send_op(FN_ADD, 32'h7fff_ffff);
        send_op(FN_ADD, 32'h8000_0000);
        send_op(FN_SUB, 32'h8000_0000);
        send_op(FN_SUB, 32'h7fff_ffff);
        send_op(FN_ADD, 32'(SEC_PER_DAY));
        send_op(FN_SUB, 32'd1);
        send_op(FN_ADD, 32'hffff_ffff);
        send_op(FN_ADD, 32'd0);
        send_op(FN_UNUSED_LO, $urandom);
        send_op(3'(FN_UNUSED_LO + 3'd1), $urandom);
        send_op(FN_UNUSED_HI, $urandom);
        send_op(FN_DEC, $urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 500 && n < 800);
            if (n == 1100) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                wait (pending == 0);
                @(posedge i_clk);
            end
            send_random_item();
        end
        idle_on = 1'b1;

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** time_of_day_hms_adjust_unit: PASSED **");
        end else begin
            $display("** time_of_day_hms_adjust_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("** time_of_day_hms_adjust_unit: FAILED **");
        $finish;
    end

endmodule

// ----- time_of_day_hms_adjust_unit.f -----
rtl/tdhms_pkg.sv
rtl/tdhms_delta.sv
rtl/tdhms_mod.sv
rtl/tdhms_split.sv
rtl/tdhms_acc.sv
rtl/time_of_day_hms_adjust_unit.sv
dv/tdhms_checker.sv
dv/tb_time_of_day_hms_adjust_unit.sv
